>>> rtl/mas_pkg.sv
// types, codes and reset constants shared by the mixer arm sequencer
package mas_pkg;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int TIMER_W    = 16;
    localparam int STEP_W     = 9;

    localparam logic [7:0]         STEP_SIZE_RST = 8'd3;
    localparam logic [TIMER_W-1:0] SETTLE_RST    = 16'd300;
    localparam logic [TIMER_W-1:0] MIX_RST       = 16'd2000;
    localparam logic [TIMER_W-1:0] SPINDOWN_RST  = 16'd500;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIX       = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPINDOWN  = 8'd3;

    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_START     = 2'd1,
        OP_STOP      = 2'd2,
        OP_WAIT_PUMP = 2'd3
    } t_opcode;

    typedef enum logic [3:0] {
        ST_UNKNOWN    = 4'd0,
        ST_GOING_UP   = 4'd1,
        ST_UP         = 4'd2,
        ST_GOING_DOWN = 4'd3,
        ST_DOWN       = 4'd4,
        ST_SETTLING   = 4'd5,
        ST_MIXING     = 4'd6,
        ST_SPINDOWN   = 4'd7,
        ST_WAIT_PUMP  = 4'd8
    } t_arm_state;

    typedef struct packed {
        logic [7:0]         step_size;
        logic [TIMER_W-1:0] settle_ticks;
        logic [TIMER_W-1:0] mix_ticks;
        logic [TIMER_W-1:0] spindown_ticks;
    } t_cfg;

    typedef struct packed {
        t_arm_state         phase;
        logic               run;
        logic [TIMER_W-1:0] timer;
    } t_state;

    typedef struct packed {
        logic signed [STEP_W-1:0] step_count;
        logic                     mixer_on;
        logic [3:0]               arm_state;
        logic                     running;
    } t_result;

endpackage

>>> rtl/mas_in_if.sv
// input item channel: opcode and end-stop levels
interface mas_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic       lower_endstop_hit;
    logic       upper_endstop_hit;

    modport source (output valid, output opcode, output lower_endstop_hit,
                    output upper_endstop_hit, input ready);
    modport sink   (input valid, input opcode, input lower_endstop_hit,
                    input upper_endstop_hit, output ready);
endinterface

>>> rtl/mas_out_if.sv
// result item channel: steps, mixer drive, arm state, running flag
interface mas_out_if;
    logic              valid;
    logic              ready;
    logic signed [8:0] step_count;
    logic              mixer_on;
    logic [3:0]        arm_state;
    logic              running;

    modport source (output valid, output step_count, output mixer_on,
                    output arm_state, output running, input ready);
    modport sink   (input valid, input step_count, input mixer_on,
                    input arm_state, input running, output ready);
endinterface

>>> rtl/mas_cfg_if.sv
// configuration write channel: register index and data
interface mas_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/mas_cfg_regs.sv
// configuration register file
module mas_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mas_cfg_if.sink       i_cfg,
    output mas_pkg::t_cfg o_cfg
);
    import mas_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_size      <= STEP_SIZE_RST;
            r_cfg.settle_ticks   <= SETTLE_RST;
            r_cfg.mix_ticks      <= MIX_RST;
            r_cfg.spindown_ticks <= SPINDOWN_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_STEP_SIZE: r_cfg.step_size      <= i_cfg.data[7:0];
                REG_SETTLE:    r_cfg.settle_ticks   <= i_cfg.data;
                REG_MIX:       r_cfg.mix_ticks      <= i_cfg.data;
                REG_SPINDOWN:  r_cfg.spindown_ticks <= i_cfg.data;
                default: ;
            endcase
        end
    end
endmodule

>>> rtl/mas_step_logic.sv
// next arm state and step count for one item
module mas_step_logic (
    input  mas_pkg::t_state              i_state,
    input  mas_pkg::t_cfg                i_cfg,
    input  logic [1:0]                   i_opcode,
    input  logic                         i_lower,
    input  logic                         i_upper,
    output mas_pkg::t_state              o_state,
    output logic signed [mas_pkg::STEP_W-1:0] o_step_count
);
    import mas_pkg::*;

    logic                     timed;
    logic                     timer_zero;
    logic [TIMER_W-1:0]       timer_dec;
    logic signed [STEP_W-1:0] step_down;
    logic signed [STEP_W-1:0] step_up;

    assign timed      = (i_state.phase == ST_SETTLING) || (i_state.phase == ST_MIXING) ||
                        (i_state.phase == ST_SPINDOWN);
    assign timer_zero = (i_state.timer == '0);
    assign timer_dec  = i_state.timer - TIMER_W'(1);
    assign step_down  = $signed({1'b0, i_cfg.step_size});
    assign step_up    = -step_down;

    always_comb begin
        o_state      = i_state;
        o_step_count = '0;
        if (t_opcode'(i_opcode) == OP_TICK) begin
            unique case (i_state.phase)
                ST_WAIT_PUMP: ;
                ST_UNKNOWN:   o_state.phase = ST_GOING_UP;
                ST_UP: begin
                    if (i_state.run) o_state.phase = ST_GOING_DOWN;
                end
                ST_GOING_DOWN: begin
                    if (!i_state.run)  o_state.phase = ST_GOING_UP;
                    else if (i_lower)  o_state.phase = ST_DOWN;
                    else               o_step_count  = step_down;
                end
                ST_DOWN: begin
                    if (!i_state.run) begin
                        o_state.phase = ST_GOING_UP;
                    end else begin
                        o_state.phase = ST_SETTLING;
                        o_state.timer = i_cfg.settle_ticks;
                    end
                end
                ST_SETTLING: begin
                    if (!timer_zero) begin
                        o_state.timer = timer_dec;
                    end else begin
                        o_state.phase = ST_MIXING;
                        o_state.timer = i_cfg.mix_ticks;
                    end
                end
                ST_MIXING: begin
                    if (!timer_zero) begin
                        o_state.timer = timer_dec;
                    end else begin
                        o_state.phase = ST_SPINDOWN;
                        o_state.timer = i_cfg.spindown_ticks;
                    end
                end
                ST_SPINDOWN: begin
                    if (!timer_zero) begin
                        o_state.timer = timer_dec;
                    end else begin
                        o_state.run   = 1'b0;
                        o_state.phase = ST_GOING_UP;
                    end
                end
                ST_GOING_UP: begin
                    if (i_upper) o_state.phase = ST_UP;
                    else         o_step_count  = step_up;
                end
                default: o_state.phase = ST_UNKNOWN;
            endcase
        end else if (!timed) begin
            // commands are dropped while a timed phase runs
            unique case (t_opcode'(i_opcode))
                OP_START: begin
                    o_state.run   = 1'b1;
                    o_state.phase = ST_UNKNOWN;
                end
                OP_STOP:      o_state.run   = 1'b0;
                OP_WAIT_PUMP: o_state.phase = ST_WAIT_PUMP;
                default: ;
            endcase
        end
    end
endmodule

>>> rtl/mixer_arm_sequencer.sv
// top level of the mixer arm sequencer
// Mixer arm sequencer: steps an arm between two end stops, dwells at the
// bottom, runs the mixer, waits for spin-down and rises again.
// Channels: i_in takes one item per handshake (tick with both end-stop
// levels, start, stop or wait-for-pump); o_out gives exactly one result
// item per input item (signed steps, mixer drive, arm state, running);
// i_cfg writes step size and the settle, mix and spin-down tick counts, is always
// ready; the user must write it only while the block is idle; the block has no check.
// Latency: a result is valid the cycle after its item is accepted.
// Throughput: one item per cycle while the receiver takes each result; the arm
// state register and the result register are each one stage, so the state
// update of one item feeds the next item directly.
// Reset (synchronous, active low): arm state unknown, not running, timer
// zero, registers back to 3/300/2000/500, no result pending.
// Receiver stall: the result register holds; i_in.ready stays high while
// the held result is being taken, and drops only while it is stalled.
module mixer_arm_sequencer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mas_in_if.sink    i_in,
    mas_cfg_if.sink   i_cfg,
    mas_out_if.source o_out
);
    import mas_pkg::*;

    t_cfg    cfg;
    t_state  r_state;
    t_state  n_state;
    t_result r_result;
    t_result n_result;
    logic    r_out_valid;
    logic    accept;
    logic signed [STEP_W-1:0] step_count;

    mas_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    mas_step_logic u_step_logic (
        .i_state      (r_state),
        .i_cfg        (cfg),
        .i_opcode     (i_in.opcode),
        .i_lower      (i_in.lower_endstop_hit),
        .i_upper      (i_in.upper_endstop_hit),
        .o_state      (n_state),
        .o_step_count (step_count)
    );

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        n_result.step_count = step_count;
        n_result.mixer_on   = (n_state.phase == ST_MIXING);
        n_result.arm_state  = n_state.phase;
        n_result.running    = n_state.run;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase <= ST_UNKNOWN;
            r_state.run   <= 1'b0;
            r_state.timer <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (accept) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.step_count = r_result.step_count;
    assign o_out.mixer_on   = r_result.mixer_on;
    assign o_out.arm_state  = r_result.arm_state;
    assign o_out.running    = r_result.running;

    // steps go out only from a traveling state, down positive and up negative
    a_step_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.step_count > 0) |-> (o_out.arm_state == ST_GOING_DOWN))
        else $error("downward steps outside going-down state");

    a_step_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.step_count < 0) |-> (o_out.arm_state == ST_GOING_UP))
        else $error("upward steps outside going-up state");

    // a command during a timed phase leaves the sequencer untouched
    a_timed_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.opcode != OP_TICK &&
         (r_state.phase == ST_SETTLING || r_state.phase == ST_MIXING ||
          r_state.phase == ST_SPINDOWN))
        |=> (r_state == $past(r_state)))
        else $error("command altered a timed phase");

    // a result follows every accepted item in the next cycle
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out.valid)
        else $error("accepted item produced no result");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result pending after reset");
endmodule
